### rtl/core/tmaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Temperature filter package
// Shared widths, register indexes, reset values and the controller commands.
// ----------------------------------------------------------------------------
package tmaf_pkg;

   localparam int WINDOW_MAX_DEFAULT = 16;

   localparam int SAMPLE_W   = 16;
   localparam int WLEN_W     = 5;
   localparam int THR_W      = 15;
   localparam int GAIN_W     = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 15;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 9'd256;

   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_LEN     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MEDIAN_ENABLE  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_AVERAGE_ENABLE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SMOOTH_ENABLE  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_JUMP_THRESHOLD = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_HIGH      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_LOW       = 3'd6;

   typedef struct packed {
      logic [WLEN_W-1:0] window_len;
      logic              median_enable;
      logic              average_enable;
      logic              smooth_enable;
      logic [THR_W-1:0]  jump_threshold;
      logic [GAIN_W-1:0] gain_high;
      logic [GAIN_W-1:0] gain_low;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      window_len:     5'd5,
      median_enable:  1'b1,
      average_enable: 1'b1,
      smooth_enable:  1'b1,
      jump_threshold: 15'd160,
      gain_high:      9'd230,
      gain_low:       9'd128
   };

   // One command word per cycle from the controller to the datapath
   typedef struct packed {
      logic load;       // capture the sample, arm the zero check
      logic rd_en;      // read both windows at rd_addr
      logic scan_chk;   // check the last median read for nonzero
      logic shift_wr;   // move the last read one entry down to wr_addr
      logic tail;       // write the newest entries, take the median
      logic div_start;  // start the average divide
      logic div_take;   // take the quotient
      logic diff;       // difference against the previous output
      logic mul;        // difference times gain
      logic add;        // previous output plus step
      logic out_load;   // load the result beat
   } cmd_type;

endpackage
`default_nettype wire

### rtl/core/tmaf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Temperature filter controller
// Sequences the window scan, the shift pass, the divide and the smoothing
// steps, and owns the handshake of both streams.
// ----------------------------------------------------------------------------
module tmaf_ctrl #(
   parameter int WINDOW_MAX = tmaf_pkg::WINDOW_MAX_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              average_enable,
   input  wire logic [$clog2(WINDOW_MAX+1)-1:0]   n_used,
   input  wire logic                              div_done,
   output logic                                   req_tready,
   output logic                                   rsp_tvalid,
   output tmaf_pkg::cmd_type                      cmd,
   output logic [$clog2(WINDOW_MAX)-1:0]          rd_addr,
   output logic [$clog2(WINDOW_MAX)-1:0]          wr_addr
);
   import tmaf_pkg::*;

   localparam int NW = $clog2(WINDOW_MAX + 1);
   localparam int AW = $clog2(WINDOW_MAX);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_SCAN   = 10'b00_0000_0010,
      S_SHIFT  = 10'b00_0000_0100,
      S_TAIL   = 10'b00_0000_1000,
      S_DSTART = 10'b00_0001_0000,
      S_DIV    = 10'b00_0010_0000,
      S_DIFF   = 10'b00_0100_0000,
      S_MUL    = 10'b00_1000_0000,
      S_ADD    = 10'b01_0000_0000,
      S_OUT    = 10'b10_0000_0000
   } state_type;

   state_type       state_ff, state_in;
   logic [NW-1:0]   cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            cnt_end;
   logic [NW-1:0]   cnt_minus2;

   assign cnt_end    = (cnt_ff == n_used);
   assign cnt_minus2 = cnt_ff - NW'(2);
   assign rd_addr    = cnt_ff[AW-1:0];
   assign wr_addr    = cnt_minus2[AW-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.rd_en    = !cnt_end;
            cmd.scan_chk = (cnt_ff != '0);
            if (cnt_end) begin
               cnt_in   = NW'(1);
               state_in = S_SHIFT;
            end else begin
               cnt_in = cnt_ff + NW'(1);
            end
         end
         S_SHIFT: begin
            // read entry cnt, write the previous read one entry lower
            cmd.rd_en    = !cnt_end;
            cmd.shift_wr = (cnt_ff > NW'(1));
            if (cnt_end) begin
               state_in = S_TAIL;
            end else begin
               cnt_in = cnt_ff + NW'(1);
            end
         end
         S_TAIL: begin
            cmd.tail = 1'b1;
            state_in = average_enable ? S_DSTART : S_DIFF;
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/tmaf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Temperature filter divider
// Restoring divide of the signed window sum by the window length, one
// quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module tmaf_div #(
   parameter int WINDOW_MAX = tmaf_pkg::WINDOW_MAX_DEFAULT
) (
   input  wire logic                                                 clock,
   input  wire logic                                                 reset,
   input  wire logic                                                 start,
   input  wire logic signed [tmaf_pkg::SAMPLE_W+$clog2(WINDOW_MAX)-1:0] dividend,
   input  wire logic [$clog2(WINDOW_MAX+1)-1:0]                      divisor,
   output logic                                                      done,
   output logic signed [tmaf_pkg::SAMPLE_W+$clog2(WINDOW_MAX)-1:0]   quotient
);
   import tmaf_pkg::*;

   localparam int SW = SAMPLE_W + $clog2(WINDOW_MAX);
   localparam int NW = $clog2(WINDOW_MAX + 1);
   localparam int CW = $clog2(SW + 1);

   logic [SW-1:0] quo_ff;
   logic [NW-1:0] rem_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic          neg_ff;
   logic [SW-1:0] mag;
   logic [NW:0]   rem_sh;
   logic [NW:0]   rem_sub;
   logic          fits;

   assign mag     = dividend[SW-1] ? (~dividend) + SW'(1) : dividend;
   assign rem_sh  = {rem_ff, quo_ff[SW-1]};
   assign fits    = (rem_sh >= {1'b0, divisor});
   assign rem_sub = rem_sh - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= mag;
         rem_ff <= '0;
         cnt_ff <= CW'(SW);
         neg_ff <= dividend[SW-1];
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SW-2:0], fits};
         rem_ff <= fits ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && cnt_ff == CW'(1)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule
`default_nettype wire

### rtl/core/tmaf_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Temperature filter datapath
// Median and average window memories, sum accumulator, median of three,
// divider and the adaptive smoothing arithmetic.
// ----------------------------------------------------------------------------
module tmaf_dpath #(
   parameter int WINDOW_MAX = tmaf_pkg::WINDOW_MAX_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire tmaf_pkg::cmd_type                      cmd,
   input  wire logic [$clog2(WINDOW_MAX)-1:0]          rd_addr,
   input  wire logic [$clog2(WINDOW_MAX)-1:0]          wr_addr,
   input  wire tmaf_pkg::cfg_type                      cfg,
   input  wire logic [$clog2(WINDOW_MAX+1)-1:0]        n_used,
   input  wire logic signed [tmaf_pkg::SAMPLE_W-1:0]   sample,
   output logic                                        div_done,
   output logic signed [tmaf_pkg::SAMPLE_W-1:0]        filtered
);
   import tmaf_pkg::*;

   localparam int NW = $clog2(WINDOW_MAX + 1);
   localparam int AW = $clog2(WINDOW_MAX);
   localparam int SW = SAMPLE_W + $clog2(WINDOW_MAX);
   localparam int DW = SAMPLE_W + 1;
   localparam int PW = DW + GAIN_W + 1;

   function automatic logic signed [SAMPLE_W-1:0] med3(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b,
      input logic signed [SAMPLE_W-1:0] c
   );
      logic signed [SAMPLE_W-1:0] m;
      if (a <= b && a <= c) begin
         m = (b <= c) ? b : c;
      end else if (b <= a && b <= c) begin
         m = (a <= c) ? a : c;
      end else begin
         m = (a <= b) ? a : b;
      end
      return m;
   endfunction

   // window memories; an entry never written reads as zero
   logic signed [SAMPLE_W-1:0] med_mem [WINDOW_MAX];
   logic signed [SAMPLE_W-1:0] avg_mem [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]      med_vld_ff;
   logic [WINDOW_MAX-1:0]      avg_vld_ff;
   logic signed [SAMPLE_W-1:0] med_rd_ff, avg_rd_ff;
   logic                       med_rv_ff, avg_rv_ff;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       all_zero_ff;
   logic signed [SAMPLE_W-1:0] ta_ff, tb_ff;
   logic signed [SW-1:0]       sum_ff;
   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [DW-1:0]       d_ff;
   logic                       big_ff;
   logic signed [PW-1:0]       p_ff;
   logic signed [SAMPLE_W-1:0] result_ff;
   logic signed [SAMPLE_W-1:0] prev_ff;
   logic signed [SAMPLE_W-1:0] out_ff;

   logic signed [SAMPLE_W-1:0] med_old, avg_old, med_src, avg_src;
   logic signed [SAMPLE_W-1:0] v1;
   logic [NW-1:0]              n_m1;
   logic [AW-1:0]              wr_idx;
   logic                       med_we, avg_we;
   logic signed [SAMPLE_W-1:0] med_wdata, avg_wdata;
   logic signed [DW-1:0]       d_in;
   logic [DW-1:0]              mag_in;
   logic [GAIN_W-1:0]          gain_sel, gain_sat;
   logic signed [PW-1:0]       p_in;
   logic signed [SW-1:0]       div_quot;

   assign med_old = med_rv_ff ? med_rd_ff : '0;
   assign avg_old = avg_rv_ff ? avg_rd_ff : '0;
   // a fresh fill makes every old entry equal to the sample
   assign med_src = all_zero_ff ? sample_ff : med_old;
   assign avg_src = all_zero_ff ? sample_ff : avg_old;

   assign v1 = (cfg.median_enable && n_used >= NW'(3)) ?
               med3(ta_ff, tb_ff, sample_ff) : sample_ff;

   assign n_m1      = n_used - NW'(1);
   assign wr_idx    = cmd.tail ? n_m1[AW-1:0] : wr_addr;
   assign med_we    = (cmd.shift_wr || cmd.tail) && (all_zero_ff || cfg.median_enable);
   assign avg_we    = (cmd.shift_wr || cmd.tail) && (all_zero_ff || cfg.average_enable);
   assign med_wdata = cmd.tail ? sample_ff : med_src;
   assign avg_wdata = cmd.tail ? (cfg.average_enable ? v1 : sample_ff) : avg_src;

   always_ff @(posedge clock) begin
      if (med_we) begin
         med_mem[wr_idx] <= med_wdata;
      end
      if (avg_we) begin
         avg_mem[wr_idx] <= avg_wdata;
      end
      if (cmd.rd_en) begin
         med_rd_ff <= med_mem[rd_addr];
         avg_rd_ff <= avg_mem[rd_addr];
         med_rv_ff <= med_vld_ff[rd_addr];
         avg_rv_ff <= avg_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         med_vld_ff <= '0;
         avg_vld_ff <= '0;
      end else begin
         if (med_we) begin
            med_vld_ff[wr_idx] <= 1'b1;
         end
         if (avg_we) begin
            avg_vld_ff[wr_idx] <= 1'b1;
         end
      end
   end

   tmaf_div #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (n_used),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign d_in     = {value_ff[SAMPLE_W-1], value_ff} - {prev_ff[SAMPLE_W-1], prev_ff};
   assign mag_in   = d_in[DW-1] ? -d_in : d_in;
   assign gain_sel = big_ff ? cfg.gain_high : cfg.gain_low;
   assign gain_sat = (gain_sel > GAIN_ONE) ? GAIN_ONE : gain_sel;
   assign p_in     = d_ff * $signed({1'b0, gain_sat});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= sample;
         sum_ff    <= '0;
      end
      if (cmd.shift_wr) begin
         ta_ff  <= tb_ff;
         tb_ff  <= med_src;
         sum_ff <= sum_ff + SW'(avg_src);
      end
      if (cmd.tail) begin
         value_ff <= v1;
         sum_ff   <= sum_ff + SW'(v1);
      end
      if (cmd.div_take) begin
         value_ff <= div_quot[SAMPLE_W-1:0];
      end
      if (cmd.diff) begin
         d_ff   <= d_in;
         big_ff <= (mag_in > {{(DW-THR_W){1'b0}}, cfg.jump_threshold});
      end
      if (cmd.mul) begin
         p_ff <= p_in;
      end
      if (cmd.add) begin
         // arithmetic shift by 8 keeps the floor of the Q8 product
         result_ff <= cfg.smooth_enable ?
                      prev_ff + $signed(p_ff[SAMPLE_W+7:8]) : value_ff;
      end
      if (cmd.out_load) begin
         out_ff <= result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         all_zero_ff <= 1'b1;
         prev_ff     <= '0;
      end else begin
         if (cmd.load) begin
            all_zero_ff <= 1'b1;
         end else if (cmd.scan_chk && med_old != '0) begin
            all_zero_ff <= 1'b0;
         end
         if (cmd.out_load) begin
            prev_ff <= result_ff;
         end
      end
   end

   assign filtered = out_ff;

endmodule
`default_nettype wire

### rtl/core/temperature_median_average_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Temperature median / average filter
// Each beat on req carries one signed Q12.4 sample and yields exactly one
// filtered Q12.4 beat on rsp. Items are worked one at a time: a new sample
// is taken only once the last result is loaded, in the cycle after it.
// The time an item takes is set by the single read port of each window
// memory, which the zero scan and the shift pass walk one entry per cycle,
// and, when the average stage is on, by the bit-serial divider for the mean.
// A finished result waits in an output register, so the next sample is
// taken while rsp is stalled. Configuration registers are written through
// csr_we / csr_addr / csr_wdata; the user must write them only while the
// filter is idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module temperature_median_average_filter_top #(
   parameter int WINDOW_MAX = tmaf_pkg::WINDOW_MAX_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [15:0]                        req_tdata,   // [15:0] sample
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [15:0]                             rsp_tdata,   // [15:0] filtered
   input  wire logic                               csr_we,
   input  wire logic [tmaf_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [tmaf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tmaf_pkg::*;

   localparam int NW   = $clog2(WINDOW_MAX + 1);
   localparam int AW   = $clog2(WINDOW_MAX);
   localparam int CMPW = (NW > WLEN_W) ? NW : WLEN_W;

   cfg_type                    cfg_ff;
   logic [CMPW-1:0]            wlen_ext;
   logic [NW-1:0]              n_used;
   cmd_type                    cmd;
   logic [AW-1:0]              rd_addr, wr_addr;
   logic                       div_done;
   logic signed [SAMPLE_W-1:0] filtered;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WINDOW_LEN:     cfg_ff.window_len     <= csr_wdata[WLEN_W-1:0];
            CSR_MEDIAN_ENABLE:  cfg_ff.median_enable  <= csr_wdata[0];
            CSR_AVERAGE_ENABLE: cfg_ff.average_enable <= csr_wdata[0];
            CSR_SMOOTH_ENABLE:  cfg_ff.smooth_enable  <= csr_wdata[0];
            CSR_JUMP_THRESHOLD: cfg_ff.jump_threshold <= csr_wdata[THR_W-1:0];
            CSR_GAIN_HIGH:      cfg_ff.gain_high      <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_LOW:       cfg_ff.gain_low       <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the window length to 1..WINDOW_MAX
   assign wlen_ext = CMPW'(cfg_ff.window_len);
   always_comb begin
      if (wlen_ext == '0) begin
         n_used = NW'(1);
      end else if (wlen_ext > CMPW'(WINDOW_MAX)) begin
         n_used = NW'(WINDOW_MAX);
      end else begin
         n_used = NW'(wlen_ext);
      end
   end

   tmaf_ctrl #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .rsp_tready     (rsp_tready),
      .average_enable (cfg_ff.average_enable),
      .n_used         (n_used),
      .div_done       (div_done),
      .req_tready     (req_tready),
      .rsp_tvalid     (rsp_tvalid),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .wr_addr        (wr_addr)
   );

   tmaf_dpath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .cfg      (cfg_ff),
      .n_used   (n_used),
      .sample   ($signed(req_tdata[SAMPLE_W-1:0])),
      .div_done (div_done),
      .filtered (filtered)
   );

   assign rsp_tdata = filtered;

   // an accepted sample takes the controller out of idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("filter still ready right after taking a sample");

   // no result can come out in the cycle after a sample is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("result raised right after a sample was taken");

   // the clamped window length stays within the window
   a_window_in_range: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |->
         (n_used != '0 && n_used <= NW'(WINDOW_MAX)))
      else $error("window length out of range");

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature median / average filter testbench
// Drives Q12.4 samples on req, with bursts and gaps, against a random
// back-pressure pattern on rsp. Each sample is run through a filter model
// kept inside the tracker class, and every rsp beat is compared with it.
// Register settings change between phases, only when the filter has drained.
// ----------------------------------------------------------------------------
module testbench;
   import tmaf_pkg::*;

   localparam int WINDOW_DEPTH  = WINDOW_MAX_DEFAULT;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int HOLD_CYCLES   = 500;
   localparam int HOLD_SPACING  = 600;
   localparam int TAIL_CYCLES   = 80;
   localparam int ERROR_PRINTS  = 100;

   typedef enum int {STYLE_WALK, STYLE_FULL, STYLE_EDGE, STYLE_ZEROS} sample_style_type;

   class filter_tracker;
      cfg_type     cfg;
      int          median_win[WINDOW_DEPTH];
      int          average_win[WINDOW_DEPTH];
      int          last_out;
      logic [15:0] filtered_due[$];
      int          errors;
      int          checked;
      int          refills;

      function new();
         cfg = CFG_RESET;
         foreach (median_win[i]) begin
            median_win[i]  = 0;
            average_win[i] = 0;
         end
         last_out = 0;
         errors   = 0;
         checked  = 0;
         refills  = 0;
      endfunction

      function void set_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
         case (addr)
            CSR_WINDOW_LEN:     cfg.window_len     = value[WLEN_W-1:0];
            CSR_MEDIAN_ENABLE:  cfg.median_enable  = value[0];
            CSR_AVERAGE_ENABLE: cfg.average_enable = value[0];
            CSR_SMOOTH_ENABLE:  cfg.smooth_enable  = value[0];
            CSR_JUMP_THRESHOLD: cfg.jump_threshold = value[THR_W-1:0];
            CSR_GAIN_HIGH:      cfg.gain_high      = value[GAIN_W-1:0];
            CSR_GAIN_LOW:       cfg.gain_low       = value[GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      function int median_of_three(int a, int b, int c);
         int lo;
         int hi;
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         hi = (hi < c) ? hi : c;
         return (lo > hi) ? lo : hi;
      endfunction

      function logic [15:0] filter_sample(logic [15:0] raw);
         int s;
         int v;
         int n;
         int sum;
         int d;
         int mag;
         int g;
         bit all_zero;
         s = int'($signed(raw));
         v = s;
         n = int'(cfg.window_len);
         if (n == 0) n = 1;
         if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;

         // an all-zero median window means no history yet: seed both windows
         all_zero = 1'b1;
         for (int i = 0; i < n; i++)
            if (median_win[i] != 0) all_zero = 1'b0;
         if (all_zero) begin
            refills++;
            for (int i = 0; i < n; i++) begin
               median_win[i]  = s;
               average_win[i] = s;
            end
         end

         if (cfg.median_enable) begin
            for (int i = 0; i < n - 1; i++) median_win[i] = median_win[i+1];
            median_win[n-1] = s;
            if (n >= 3)
               v = median_of_three(median_win[n-3], median_win[n-2], median_win[n-1]);
         end

         if (cfg.average_enable) begin
            for (int i = 0; i < n - 1; i++) average_win[i] = average_win[i+1];
            average_win[n-1] = v;
            sum = 0;
            for (int i = 0; i < n; i++) sum += average_win[i];
            v = sum / n;
         end

         // step is floor(d * g / 256), so shift arithmetically
         if (cfg.smooth_enable) begin
            d   = v - last_out;
            mag = (d < 0) ? -d : d;
            g   = (mag > int'(cfg.jump_threshold)) ? int'(cfg.gain_high) : int'(cfg.gain_low);
            if (g > 256) g = 256;
            v = last_out + ((d * g) >>> 8);
         end

         last_out = v;
         return v[15:0];
      endfunction

      function void note_sample(logic [15:0] raw);
         filtered_due.push_back(filter_sample(raw));
      endfunction

      function void check_result(logic [15:0] got);
         logic [15:0] want;
         if (filtered_due.size() == 0) begin
            errors++;
            if (errors <= ERROR_PRINTS)
               $error("filtered: no beat expected, actual %0d", $signed(got));
         end else begin
            want = filtered_due.pop_front();
            checked++;
            if (got !== want) begin
               errors++;
               if (errors <= ERROR_PRINTS)
                  $error("filtered: expected %0d, actual %0d", $signed(want), $signed(got));
            end
         end
      endfunction

      function int pending();
         return filtered_due.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [15:0]           req_tdata  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [15:0]           rsp_tdata;

   filter_tracker sb;
   int            rsp_beats        = 0;
   int            samples_sent     = 0;
   int            settings_applied = 0;
   int            burst_left       = 0;
   int            walk_level       = 400;

   temperature_median_average_filter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] sample
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [15:0] filtered
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
         rsp_beats++;
      end
   end

   // receiver: stretches of different readiness, plus a long hold-off now and then
   initial begin
      int mode_left;
      int ready_pct;
      int next_hold;
      mode_left = 0;
      ready_pct = 100;
      next_hold = 200;
      forever begin
         @(posedge clock);
         if (rsp_beats >= next_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            next_hold = rsp_beats + HOLD_SPACING;
         end
         if (mode_left == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 75;
               2: ready_pct = 40;
               default: ready_pct = 10;
            endcase
            mode_left = $urandom_range(16, 200);
         end
         mode_left--;
         rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
      end
   end

   function automatic cfg_type make_cfg(int wlen, bit med, bit avg, bit smo,
                                        int thr, int gh, int gl);
      cfg_type c;
      c.window_len     = WLEN_W'(wlen);
      c.median_enable  = med;
      c.average_enable = avg;
      c.smooth_enable  = smo;
      c.jump_threshold = THR_W'(thr);
      c.gain_high      = GAIN_W'(gh);
      c.gain_low       = GAIN_W'(gl);
      return c;
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      case ($urandom_range(0, 9))
         0: c.window_len = '0;
         1: c.window_len = WLEN_W'($urandom_range(17, 31));
         2: c.window_len = WLEN_W'(16);
         default: c.window_len = WLEN_W'($urandom_range(1, 16));
      endcase
      c.median_enable  = ($urandom_range(0, 9) < 7);
      c.average_enable = ($urandom_range(0, 9) < 7);
      c.smooth_enable  = ($urandom_range(0, 9) < 7);
      case ($urandom_range(0, 9))
         0: c.jump_threshold = '0;
         1: c.jump_threshold = THR_W'($urandom_range(0, 32767));
         default: c.jump_threshold = THR_W'($urandom_range(0, 400));
      endcase
      case ($urandom_range(0, 9))
         0: c.gain_high = GAIN_ONE;
         1: c.gain_high = GAIN_W'($urandom_range(257, 511));
         2: c.gain_high = '0;
         default: c.gain_high = GAIN_W'($urandom_range(0, 256));
      endcase
      case ($urandom_range(0, 9))
         0: c.gain_low = GAIN_ONE;
         1: c.gain_low = GAIN_W'($urandom_range(257, 511));
         2: c.gain_low = '0;
         default: c.gain_low = GAIN_W'($urandom_range(0, 256));
      endcase
      return c;
   endfunction

   function automatic logic [15:0] pick_sample(sample_style_type style);
      int          r;
      logic [15:0] v;
      r = $urandom_range(0, 99);
      case (style)
         STYLE_WALK: begin
            // slow drift with the odd jump past the threshold
            if (r < 4) walk_level = int'($urandom_range(0, 4000)) - 2000;
            else walk_level = walk_level + int'($urandom_range(0, 80)) - 40;
            if (walk_level > 32767) walk_level = 32767;
            if (walk_level < -32768) walk_level = -32768;
            v = walk_level[15:0];
         end
         STYLE_FULL: v = 16'($urandom);
         STYLE_EDGE: begin
            case (r % 6)
               0: v = 16'h8000;
               1: v = 16'h7FFF;
               2: v = 16'h0000;
               3: v = 16'hFFFF;
               4: v = 16'h0001;
               default: v = 16'($urandom);
            endcase
         end
         default: v = (r < 60) ? 16'h0000 : 16'($urandom);
      endcase
      return v;
   endfunction

   task automatic send_block(input logic [15:0] samples[$]);
      int gap;
      foreach (samples[i]) begin
         req_tvalid <= 1'b1;
         req_tdata  <= samples[i];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sb.note_sample(samples[i]);
         samples_sent++;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(0, 24);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] value);
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(addr, value);
   endtask

   // wait for the filter to drain, then rewrite every register
   task automatic apply_config(input cfg_type c);
      while (sb.pending() != 0) @(posedge clock);
      csr_we <= 1'b1;
      write_csr(CSR_WINDOW_LEN, {10'd0, c.window_len});
      write_csr(CSR_MEDIAN_ENABLE, {14'd0, c.median_enable});
      write_csr(CSR_AVERAGE_ENABLE, {14'd0, c.average_enable});
      write_csr(CSR_SMOOTH_ENABLE, {14'd0, c.smooth_enable});
      write_csr(CSR_JUMP_THRESHOLD, c.jump_threshold);
      write_csr(CSR_GAIN_HIGH, {6'd0, c.gain_high});
      write_csr(CSR_GAIN_LOW, {6'd0, c.gain_low});
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   initial begin
      logic [15:0]      batch[$];
      sample_style_type style;
      int               count;
      int               random_sent;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: first beat seeds the empty windows, then field extremes
      batch = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
      send_block(batch);
      // zero length acts as one; high gain above 256 saturates, zero threshold
      apply_config(make_cfg(0, 1, 1, 1, 0, 511, 0));
      batch = '{16'h0064, 16'hFF9C, 16'h7FFF};
      send_block(batch);
      // length above the window depth saturates; full threshold, low gain 256
      apply_config(make_cfg(31, 1, 1, 1, 32767, 0, 256));
      batch = '{16'h8000, 16'h0032, 16'h7FFF};
      send_block(batch);
      // length two: median shifts but passes the sample through
      apply_config(make_cfg(2, 1, 0, 0, 160, 230, 128));
      batch = '{16'h0010, 16'h8000, 16'h0020};
      send_block(batch);
      // median off, unity high gain
      apply_config(make_cfg(3, 0, 1, 1, 5, 256, 1));
      batch = '{16'h0100, 16'hFF00, 16'h0000};
      send_block(batch);
      // every stage off
      apply_config(make_cfg(16, 0, 0, 0, 160, 230, 128));
      batch = '{16'h1234, 16'hEDCC};
      send_block(batch);
      apply_config(make_cfg(16, 1, 0, 1, 32767, 0, 256));
      batch = '{16'h0000, 16'h7FFF};
      send_block(batch);

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         count = $urandom_range(20, 120);
         apply_config(random_config());
         style = sample_style_type'($urandom_range(0, 3));
         batch.delete();
         repeat (count) batch.push_back(pick_sample(style));
         send_block(batch);
         random_sent += count;
      end

      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d samples under %0d register settings, %0d beats checked.",
               samples_sent, settings_applied, sb.checked);
      $display("Windows were seeded from an empty history %0d times.", sb.refills);
      if (sb.errors == 0) begin
         $display("** temperature_median_average_filter_top: PASSED **");
      end else begin
         $display("** temperature_median_average_filter_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** temperature_median_average_filter_top: FAILED **");
      $finish;
   end

endmodule
